### design/bmb_pkg.sv
// bmb_pkg: shared constants for the box mean blur core.
// Register indexes, reset values and default size limits.
// No dependencies.
`default_nettype none
package bmb_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 128;
   localparam int MAX_RADIUS_DEF = 15;

   localparam int LEVEL_W = 8;
   localparam int POS_W   = 7;
   localparam int DIM_W   = 8;
   localparam int RAD_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL    = 3'd4;

   // register reset values
   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 8'd128;
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 8'd128;
   localparam logic [RAD_W-1:0]   RADIUS_X_RST     = 4'd1;
   localparam logic [RAD_W-1:0]   RADIUS_Y_RST     = 4'd1;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 8'd255;

   // transaction kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

endpackage
`default_nettype wire

### design/bmb_ram.sv
// bmb_ram: generic simple dual-port RAM, one write and one registered read port.
// Contents are not reset. No dependencies.
`default_nettype none
module bmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/bmb_div.sv
// bmb_div: restoring unsigned divider, one quotient bit per cycle.
// done pulses for one cycle with the quotient.
// No dependencies.
`default_nettype none
module bmb_div #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
`default_nettype wire

### design/box_mean_blur_core.sv
// box_mean_blur_core: box mean filter over a frame store; uses bmb_pkg, bmb_ram, bmb_div.
// Pixel write: stored at the accept edge if inside the image, busy stays low, no result.
// Query outside the image: result strobe in the cycle after accept.
// Query inside: busy through the scan (window pixels read one per cycle), S_LAST, S_START
// and the divider wait (numerator width 20 at defaults); strobe in the cycle busy drops.
// Results cannot be stalled. Sync reset restores register defaults; frame store kept.
`default_nettype none
module box_mean_blur_core #(
   parameter int MAX_WIDTH  = bmb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmb_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = bmb_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_kind,
   input  wire logic [bmb_pkg::POS_W-1:0]        req_pos_x,
   input  wire logic [bmb_pkg::POS_W-1:0]        req_pos_y,
   input  wire logic [bmb_pkg::LEVEL_W-1:0]      req_level,
   output logic                                  rsp_strobe,
   output logic      [bmb_pkg::LEVEL_W-1:0]      rsp_blurred,
   output logic                                  rsp_valid_res,
   output logic      [bmb_pkg::POS_W-1:0]        rsp_out_x,
   output logic      [bmb_pkg::POS_W-1:0]        rsp_out_y,
   input  wire logic                             csr_we,
   input  wire logic [bmb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bmb_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int GW    = $clog2(MAXD + 256) + 1;
   localparam int WIN   = 2 * MAX_RADIUS + 1;
   localparam int CNT_W = $clog2(WIN * WIN + 1);
   localparam int SUM_W = $clog2(WIN * WIN * 255 + 1);
   localparam int NUM_W = SUM_W + 2;
   localparam int DEN_W = CNT_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_LAST  = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;

   // configuration registers
   logic [bmb_pkg::DIM_W-1:0]   img_w_ff, img_h_ff;
   logic [bmb_pkg::RAD_W-1:0]   rad_x_ff, rad_y_ff;
   logic [bmb_pkg::LEVEL_W-1:0] max_level_ff;

   logic [2:0]       state_ff, state_in;
   logic [GW-1:0]    x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [GW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_pend_ff;
   logic [bmb_pkg::POS_W-1:0] qx_ff, qx_in, qy_ff, qy_in;

   logic                        strobe_ff, strobe_in;
   logic [bmb_pkg::LEVEL_W-1:0] blurred_ff, blurred_in;
   logic                        valid_ff, valid_in;
   logic [bmb_pkg::POS_W-1:0]   ox_ff, ox_in, oy_ff, oy_in;

   logic          accept;
   logic [GW-1:0] w_eff, h_eff, rx_eff, ry_eff, xg, yg, x_hi, y_hi;
   logic          in_image;

   logic                        ram_we, ram_re;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [bmb_pkg::LEVEL_W-1:0] rd_data;

   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [DEN_W-1:0] div_den;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // geometry of the requested position against the clipped image
   always_comb begin
      w_eff  = (GW'(img_w_ff) > GW'(MAX_WIDTH))  ? GW'(MAX_WIDTH)  : GW'(img_w_ff);
      h_eff  = (GW'(img_h_ff) > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : GW'(img_h_ff);
      rx_eff = (GW'(rad_x_ff) > GW'(MAX_RADIUS)) ? GW'(MAX_RADIUS) : GW'(rad_x_ff);
      ry_eff = (GW'(rad_y_ff) > GW'(MAX_RADIUS)) ? GW'(MAX_RADIUS) : GW'(rad_y_ff);
      xg     = GW'(req_pos_x);
      yg     = GW'(req_pos_y);
      in_image = (xg < w_eff) && (yg < h_eff);
      x_hi   = xg + rx_eff;
      y_hi   = yg + ry_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff     <= bmb_pkg::IMAGE_WIDTH_RST;
         img_h_ff     <= bmb_pkg::IMAGE_HEIGHT_RST;
         rad_x_ff     <= bmb_pkg::RADIUS_X_RST;
         rad_y_ff     <= bmb_pkg::RADIUS_Y_RST;
         max_level_ff <= bmb_pkg::MAX_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bmb_pkg::CSR_IMAGE_WIDTH:  img_w_ff     <= csr_data;
            bmb_pkg::CSR_IMAGE_HEIGHT: img_h_ff     <= csr_data;
            bmb_pkg::CSR_RADIUS_X:     rad_x_ff     <= csr_data[bmb_pkg::RAD_W-1:0];
            bmb_pkg::CSR_RADIUS_Y:     rad_y_ff     <= csr_data[bmb_pkg::RAD_W-1:0];
            bmb_pkg::CSR_MAX_LEVEL:    max_level_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // frame store ports
   assign ram_we  = accept && (req_kind == bmb_pkg::KIND_WRITE) && in_image;
   assign wr_addr = AW'(AW'(req_pos_y) * AW'(MAX_WIDTH) + AW'(req_pos_x));
   assign ram_re  = (state_ff == S_SCAN);
   assign rd_addr = AW'(AW'(cy_ff) * AW'(MAX_WIDTH) + AW'(cx_ff));

   bmb_ram #(
      .WIDTH (bmb_pkg::LEVEL_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (req_level),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rounded mean: (2*sum + count) / (2*count)
   assign div_start = (state_ff == S_START);
   assign div_num   = NUM_W'({sum_ff, 1'b0}) + NUM_W'(cnt_ff);
   assign div_den   = {cnt_ff, 1'b0};

   bmb_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in   = state_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      strobe_in  = 1'b0;
      blurred_in = blurred_ff;
      valid_in   = valid_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;

      // read data arrives in the cycle after each scan address
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data);
         cnt_in = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == bmb_pkg::KIND_QUERY)) begin
               qx_in = req_pos_x;
               qy_in = req_pos_y;
               if (in_image) begin
                  x0_in    = (xg > rx_eff) ? (xg - rx_eff) : '0;
                  cx_in    = (xg > rx_eff) ? (xg - rx_eff) : '0;
                  cy_in    = (yg > ry_eff) ? (yg - ry_eff) : '0;
                  x1_in    = (x_hi > w_eff - 1'b1) ? (w_eff - 1'b1) : x_hi;
                  y1_in    = (y_hi > h_eff - 1'b1) ? (h_eff - 1'b1) : y_hi;
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = S_SCAN;
               end else begin
                  strobe_in  = 1'b1;
                  blurred_in = '0;
                  valid_in   = 1'b0;
                  ox_in      = req_pos_x;
                  oy_in      = req_pos_y;
               end
            end
         end
         S_SCAN: begin
            if (cx_ff == x1_ff) begin
               cx_in = x0_ff;
               cy_in = cy_ff + 1'b1;
               if (cy_ff == y1_ff) begin
                  state_in = S_LAST;
               end
            end else begin
               cx_in = cx_ff + 1'b1;
            end
         end
         S_LAST:  state_in = S_START;
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (div_done) begin
               strobe_in  = 1'b1;
               blurred_in = (div_quot > NUM_W'(max_level_ff)) ? max_level_ff
                                                             : div_quot[bmb_pkg::LEVEL_W-1:0];
               valid_in   = 1'b1;
               ox_in      = qx_ff;
               oy_in      = qy_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= ram_re;
         strobe_ff  <= strobe_in;
      end
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      blurred_ff <= blurred_in;
      valid_ff   <= valid_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_blurred   = blurred_ff;
   assign rsp_valid_res = valid_ff;
   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;

   // a result only follows an accepted query or a finished division
   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start) || $past(busy)))
      else $error("result strobe without a pending query");

   // a valid mean never exceeds the white level
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_valid_res) |-> (rsp_blurred <= max_level_ff))
      else $error("blurred value above max_level");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WAIT))
      else $error("divider done outside wait state");

endmodule
`default_nettype wire
